### sv/ccid_pkg.sv
// Shared types, constants and header table for the CCID T=1 I-block framer.
package ccid_pkg;

    // Largest APDU that fits in one I-block.
    localparam logic [7:0] MAX_APDU_BYTES = 8'd254;
    // CCID bulk-out data block message type.
    localparam logic [7:0] XFR_TYPE = 8'h6F;
    // T=1 prologue plus EDC bytes counted in the CCID length field.
    localparam logic [8:0] LEN_OVERHEAD = 9'd4;
    // Bit of the PCB that carries the T=1 send sequence number.
    localparam int unsigned PCB_SEQ_BIT = 6;

    // Header positions: 10 CCID header bytes followed by NAD, PCB and LEN.
    localparam int unsigned HDR_BYTES = 13;
    localparam int unsigned HDR_IDX_W = $clog2(HDR_BYTES);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_INDEX   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_NUMBER  = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [7:0] NODE_ADDRESS_RST = 8'h10;
    localparam logic [7:0] WAIT_INDEX_RST   = 8'h04;
    localparam logic [7:0] SLOT_NUMBER_RST  = 8'h00;

    // Depth of the command queue between the front and the back.
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // One classified request, with everything the back needs to emit its bytes.
    typedef struct packed {
        logic       is_error;
        logic       has_header;
        logic       has_data;
        logic       has_edc;
        logic [7:0] data_byte;
        logic [7:0] edc_byte;
        logic [7:0] apdu_len;
        logic [7:0] slot;
        logic [7:0] seq;
        logic [7:0] wait_idx;
        logic [7:0] nad;
        logic [7:0] pcb;
    } cmd_t;

    // Phase of the back end while it expands one command.
    typedef enum logic [2:0] {
        BE_NEW,
        BE_HDR,
        BE_DATA,
        BE_EDC,
        BE_ERR
    } be_state_t;

    // Header byte at a given position of the CCID header and T=1 prologue.
    function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                            input cmd_t c);
        logic [8:0] total;
        logic [7:0] b;
        total = {1'b0, c.apdu_len} + LEN_OVERHEAD;
        case (idx)
            4'd0:    b = XFR_TYPE;
            4'd1:    b = total[7:0];
            4'd2:    b = {7'd0, total[8]};
            4'd5:    b = c.slot;
            4'd6:    b = c.seq;
            4'd7:    b = c.wait_idx;
            4'd10:   b = c.nad;
            4'd11:   b = c.pcb;
            4'd12:   b = c.apdu_len;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

### sv/ccid_fe.sv
// Front end: configuration registers, message tracking and request classification.
module ccid_fe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          q_full,
    input  logic [7:0]                    apdu_byte,
    input  logic [7:0]                    apdu_length,
    input  logic                          write_enable,
    input  logic [ccid_pkg::CFG_IDX_W-1:0] reg_index,
    input  logic [7:0]                    write_data,
    output logic                          cmd_valid,
    output ccid_pkg::cmd_t                cmd
);

    logic [7:0] node_address_reg;
    logic [7:0] wait_index_reg;
    logic [7:0] slot_number_reg;

    logic [7:0] byte_position_reg, byte_position_next;
    logic [7:0] running_edc_reg, running_edc_next;
    logic       block_seq_reg, block_seq_next;
    logic [7:0] message_seq_reg, message_seq_next;

    logic       accept;
    logic       len_err;
    logic       starting;
    logic       empty_msg;
    logic       finish;
    logic [7:0] pcb;
    logic [7:0] edc_base;
    logic [7:0] edc_new;
    logic [7:0] pos_new;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= ccid_pkg::NODE_ADDRESS_RST;
            wait_index_reg   <= ccid_pkg::WAIT_INDEX_RST;
            slot_number_reg  <= ccid_pkg::SLOT_NUMBER_RST;
        end
        else if (write_enable)
        begin
            case (reg_index)
                ccid_pkg::REG_NODE_ADDRESS: node_address_reg <= write_data;
                ccid_pkg::REG_WAIT_INDEX:   wait_index_reg   <= write_data;
                ccid_pkg::REG_SLOT_NUMBER:  slot_number_reg  <= write_data;
                default:                    ;
            endcase
        end
    end

    // Classify the incoming request and work out the message state after it.
    always_comb
    begin
        accept    = push && !q_full;
        len_err   = apdu_length > ccid_pkg::MAX_APDU_BYTES;
        starting  = (byte_position_reg == 8'd0);
        empty_msg = starting && (apdu_length == 8'd0);
        pcb       = 8'(block_seq_reg) << ccid_pkg::PCB_SEQ_BIT;
        edc_base  = starting ? (node_address_reg ^ pcb ^ apdu_length) : running_edc_reg;
        edc_new   = edc_base ^ apdu_byte;
        pos_new   = byte_position_reg + 8'd1;
        finish    = empty_msg || (pos_new >= apdu_length);

        byte_position_next = byte_position_reg;
        running_edc_next   = running_edc_reg;
        block_seq_next     = block_seq_reg;
        message_seq_next   = message_seq_reg;
        if (accept && !len_err)
        begin
            if (finish)
            begin
                byte_position_next = 8'd0;
                running_edc_next   = 8'd0;
                block_seq_next     = !block_seq_reg;
                message_seq_next   = message_seq_reg + 8'd1;
            end
            else
            begin
                byte_position_next = pos_new;
                running_edc_next   = edc_new;
            end
        end

        cmd_valid       = accept;
        cmd.is_error    = len_err;
        cmd.has_header  = !len_err && starting;
        cmd.has_data    = !len_err && !empty_msg;
        cmd.has_edc     = !len_err && finish;
        cmd.data_byte   = apdu_byte;
        cmd.edc_byte    = empty_msg ? edc_base : edc_new;
        cmd.apdu_len    = apdu_length;
        cmd.slot        = slot_number_reg;
        cmd.seq         = message_seq_reg;
        cmd.wait_idx    = wait_index_reg;
        cmd.nad         = node_address_reg;
        cmd.pcb         = pcb;
    end

    // Message state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= 8'd0;
            running_edc_reg   <= 8'd0;
            block_seq_reg     <= 1'b0;
            message_seq_reg   <= 8'd0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            running_edc_reg   <= running_edc_next;
            block_seq_reg     <= block_seq_next;
            message_seq_reg   <= message_seq_next;
        end
    end

endmodule

### sv/ccid_cmdq.sv
// Short command queue that decouples the front end from the byte emitter.
module ccid_cmdq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    input  ccid_pkg::cmd_t push_cmd,
    output logic           full,
    output logic           head_valid,
    output ccid_pkg::cmd_t head_cmd,
    input  logic           pop_head
);

    ccid_pkg::cmd_t                   entry_reg [ccid_pkg::CMDQ_DEPTH];
    logic [ccid_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [ccid_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [ccid_pkg::CMDQ_PTR_W:0]    count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    // Occupancy flags, head entry and next fill count.
    always_comb
    begin
        full       = (count_reg == (ccid_pkg::CMDQ_PTR_W + 1)'(ccid_pkg::CMDQ_DEPTH));
        head_valid = (count_reg != '0);
        head_cmd   = entry_reg[rd_ptr_reg];
        do_push    = push_valid && !full;
        do_pop     = pop_head && head_valid;
        count_next = count_reg + (ccid_pkg::CMDQ_PTR_W + 1)'(do_push)
                               - (ccid_pkg::CMDQ_PTR_W + 1)'(do_pop);
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (ccid_pkg::CMDQ_PTR_W + 1)'(ccid_pkg::CMDQ_DEPTH))
        else $error("command queue count exceeds depth");

endmodule

### sv/ccid_be.sv
// Back end: expands queued commands into frame bytes behind an output register.
module ccid_be (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  ccid_pkg::cmd_t head_cmd,
    output logic           head_pop,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     frame_byte,
    output logic           last_of_frame,
    output logic           length_error
);

    ccid_pkg::be_state_t                 state_reg, state_next;
    ccid_pkg::be_state_t                 phase;
    logic [ccid_pkg::HDR_IDX_W-1:0]      hdr_idx_reg, hdr_idx_next;
    logic                                out_valid_reg, out_valid_next;
    logic [7:0]                          out_byte_reg, out_byte_next;
    logic                                out_last_reg, out_last_next;
    logic                                out_err_reg, out_err_next;
    logic                                advance;
    logic                                done;

    // Choose the phase, the byte to emit and the next phase.
    always_comb
    begin
        advance = head_valid && (!out_valid_reg || pop);

        if (state_reg != ccid_pkg::BE_NEW)
        begin
            phase = state_reg;
        end
        else if (head_cmd.is_error)
        begin
            phase = ccid_pkg::BE_ERR;
        end
        else if (head_cmd.has_header)
        begin
            phase = ccid_pkg::BE_HDR;
        end
        else if (head_cmd.has_data)
        begin
            phase = ccid_pkg::BE_DATA;
        end
        else
        begin
            phase = ccid_pkg::BE_EDC;
        end

        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        out_valid_next = out_valid_reg && !pop;
        state_next     = state_reg;
        hdr_idx_next   = hdr_idx_reg;
        done           = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            out_err_next   = 1'b0;
            case (phase)
                ccid_pkg::BE_HDR:
                begin
                    out_byte_next = ccid_pkg::hdr_byte(hdr_idx_reg, head_cmd);
                    if (hdr_idx_reg == ccid_pkg::HDR_LAST)
                    begin
                        hdr_idx_next = '0;
                        state_next   = head_cmd.has_data ? ccid_pkg::BE_DATA
                                                         : ccid_pkg::BE_EDC;
                    end
                    else
                    begin
                        hdr_idx_next = hdr_idx_reg + 1'b1;
                        state_next   = ccid_pkg::BE_HDR;
                    end
                end
                ccid_pkg::BE_DATA:
                begin
                    out_byte_next = head_cmd.data_byte;
                    if (head_cmd.has_edc)
                    begin
                        state_next = ccid_pkg::BE_EDC;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                ccid_pkg::BE_EDC:
                begin
                    out_byte_next = head_cmd.edc_byte;
                    out_last_next = 1'b1;
                    done          = 1'b1;
                end
                default:
                begin
                    out_byte_next = 8'd0;
                    out_err_next  = 1'b1;
                    done          = 1'b1;
                end
            endcase
            if (done)
            begin
                state_next   = ccid_pkg::BE_NEW;
                hdr_idx_next = '0;
            end
        end

        head_pop      = advance && done;
        empty         = !out_valid_reg;
        frame_byte    = out_byte_reg;
        last_of_frame = out_last_reg;
        length_error  = out_err_reg;
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ccid_pkg::BE_NEW;
            hdr_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hdr_idx_reg   <= hdr_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    // An error result is a lone zero byte that never closes a frame.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (out_byte_reg == 8'd0 && !out_last_reg))
        else $error("malformed error result");

    // A command stays at the queue head until its last byte is emitted.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ccid_pkg::BE_NEW) |-> head_valid)
        else $error("command left the queue mid-expansion");

    // The header index only moves while the header is being emitted.
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ccid_pkg::BE_HDR) |-> (hdr_idx_reg == '0))
        else $error("header index out of step with sequencer");

endmodule

### sv/ccid_t1_iblock_framer.sv
// Top level of the CCID XfrBlock / T=1 I-block framer.
// Each accepted request carries one APDU byte and its message length. The front end
// classifies it and updates the message state in the cycle it is taken, so a new
// request can be taken every cycle while the 4-entry command queue has room. The back
// end emits one frame byte per cycle while its output register is empty or popped: a data
// byte, plus the EDC on the last byte of a message, and the 13-byte CCID header and T=1
// prologue before the first byte of a message. An over-long length gives one error byte.
// Sustained throughput is one request per cycle during the data phase while pop is high;
// the back end's single byte per cycle sets the rate, and results wait in a one-entry
// output register, so while pop is low input acceptance continues only until the command
// queue fills, after which full stays high until results are taken.
module ccid_t1_iblock_framer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     apdu_byte,
    input  logic [7:0]                     apdu_length,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     frame_byte,
    output logic                           last_of_frame,
    output logic                           length_error,
    input  logic                           write_enable,
    input  logic [ccid_pkg::CFG_IDX_W-1:0] reg_index,
    input  logic [7:0]                     write_data
);

    logic           cmd_valid;
    ccid_pkg::cmd_t cmd;
    logic           head_valid;
    ccid_pkg::cmd_t head_cmd;
    logic           head_pop;

    // Request classification and message tracking.
    ccid_fe u_fe (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .q_full       (full),
        .apdu_byte    (apdu_byte),
        .apdu_length  (apdu_length),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    // Queue between front and back.
    ccid_cmdq u_cmdq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_cmd   (cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop_head   (head_pop)
    );

    // Byte emitter.
    ccid_be u_be (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_pop      (head_pop),
        .pop           (pop),
        .empty         (empty),
        .frame_byte    (frame_byte),
        .last_of_frame (last_of_frame),
        .length_error  (length_error)
    );

endmodule
